FILE: sv/minhash_signature_builder_macros.svh
// Assertion macros shared by the signature builder RTL.
`ifndef MINHASH_SIGNATURE_BUILDER_MACROS_SVH
`define MINHASH_SIGNATURE_BUILDER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define MHSB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every edge, reset included.
`define MHSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MHSB_ASSERT(lbl, clk, rst_n, prop, msg)
`define MHSB_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/mhsb_pkg.sv
// Shared types and constants of the MinHash signature builder.
package mhsb_pkg;

    localparam int CMD_W   = 2;
    localparam int SIG_W   = 8;
    localparam int VALUE_W = 17;
    localparam int MASK_W  = 16;
    localparam int COL_W   = 4;

    // Empty entry marker, all ones over the value width
    localparam logic [VALUE_W-1:0] SENTINEL = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_UPDATE = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    // Control broadcast to every column lane
    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic               fresh;
        logic [SIG_W-1:0]   slot;
        logic [VALUE_W-1:0] rank;
        logic [MASK_W-1:0]  mask;
    } t_lane_ctrl;

endpackage

FILE: sv/mhsb_lane.sv
// One column lane: signature memory for the column plus min update.
module mhsb_lane #(
    parameter int NUM_SLOTS = 256,
    parameter int LANE      = 0
) (
    input  logic                        i_clk,
    input  mhsb_pkg::t_lane_ctrl        i_ctrl,
    output logic [mhsb_pkg::VALUE_W-1:0] o_rd_data
);
    import mhsb_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [VALUE_W-1:0] r_mem [0:NUM_SLOTS-1];
    logic [VALUE_W-1:0] r_rd;
    logic [VALUE_W-1:0] n_wr;
    logic [SLOT_W-1:0]  addr;
    logic               hit;

    assign addr = i_ctrl.slot[SLOT_W-1:0];

    generate
        if (LANE < MASK_W) begin : g_masked
            assign hit = i_ctrl.mask[LANE];
        end else begin : g_unmasked
            assign hit = 1'b0;
        end
    endgenerate

    always_comb begin
        if (i_ctrl.fresh) begin
            n_wr = hit ? i_ctrl.rank : SENTINEL;
        end else if (hit && (i_ctrl.rank < r_rd)) begin
            n_wr = i_ctrl.rank;
        end else begin
            n_wr = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_en) begin
            r_rd <= r_mem[addr];
        end
        if (i_ctrl.wr_en) begin
            r_mem[addr] <= n_wr;
        end
    end

    assign o_rd_data = r_rd;

endmodule

FILE: sv/mhsb_merge.sv
// Merge stage: pick the requested column from the lanes and mark empty entries.
module mhsb_merge #(
    parameter int NUM_COLUMNS = 16
) (
    input  logic [mhsb_pkg::VALUE_W-1:0] i_lane_data [NUM_COLUMNS],
    input  logic [mhsb_pkg::COL_W-1:0]   i_col,
    input  logic                         i_force_empty,
    output logic [mhsb_pkg::VALUE_W-1:0] o_value,
    output logic                         o_empty
);
    import mhsb_pkg::*;

    logic [VALUE_W-1:0] sel;

    always_comb begin
        sel = SENTINEL;
        for (int k = 0; k < NUM_COLUMNS; k++) begin
            if (int'(i_col) == k) begin
                sel = i_lane_data[k];
            end
        end
    end

    assign o_value = i_force_empty ? SENTINEL : sel;
    assign o_empty = (o_value == SENTINEL);

endmodule

FILE: sv/minhash_signature_builder.sv
// Top level of the permutation MinHash signature builder.
// The block keeps one signature entry per column and per signature slot, the
// smallest permuted row rank seen, in one memory lane per column; all lanes work
// on the same beat side by side. Each input beat carries a command in tuser:
// update (every marked column of the slot keeps the smaller of its entry and the
// rank), read (one result beat with the entry and an empty flag) or clear (every
// slot emptied at once through one valid flip-flop per slot, so no clearing pass
// is needed after reset or after a clear). An empty entry reads as all ones.
// Updates with a rank of zero or above MAX_ROWS, or with a slot at or beyond
// NUM_SIGNATURES, are dropped; reads beyond the slots or columns return empty.
// Sequence: a clear, an unused command or a dropped update ends in the accept cycle.
// An update or a read reads the lane memories into a register in the accept cycle,
// then in ST_LOOK writes the new minimum back (update) or moves the selected entry
// into the result register (read); no beat is taken while in ST_LOOK. A read stays in
// ST_LOOK for as long as the previous result beat is still held on the output.
`include "minhash_signature_builder_macros.svh"

module minhash_signature_builder #(
    parameter int NUM_COLUMNS    = 16,
    parameter int NUM_SIGNATURES = 256,
    parameter int MAX_ROWS       = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beats
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: sig_index[7:0], row_rank[24:8], column_mask[40:25], read_column[44:41]
    input  logic [47:0] i_s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  i_s_tuser,
    // result beats
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: sig_value[16:0]
    output logic [23:0] o_m_tdata,
    // tuser: sig_empty[0]
    output logic [0:0]  o_m_tuser
);
    import mhsb_pkg::*;

    // Only slots the sig_index field can reach get storage
    localparam int NUM_SLOTS = (NUM_SIGNATURES < (2 ** SIG_W)) ? NUM_SIGNATURES
                                                               : (2 ** SIG_W);
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_LOOK
    } t_state;

    t_state               r_state;
    logic                 r_is_upd;
    logic [SIG_W-1:0]     r_slot;
    logic [VALUE_W-1:0]   r_rank;
    logic [MASK_W-1:0]    r_mask;
    logic [COL_W-1:0]     r_col;
    logic                 r_bad;
    logic [NUM_SLOTS-1:0] r_slot_valid;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_value;
    logic                 r_out_empty;

    // Unpack the input beat
    logic [SIG_W-1:0]   in_sig;
    logic [VALUE_W-1:0] in_rank;
    logic [MASK_W-1:0]  in_mask;
    logic [COL_W-1:0]   in_col;
    t_cmd               in_cmd;

    assign in_sig  = i_s_tdata[SIG_W-1:0];
    assign in_rank = i_s_tdata[SIG_W+VALUE_W-1:SIG_W];
    assign in_mask = i_s_tdata[SIG_W+VALUE_W+MASK_W-1:SIG_W+VALUE_W];
    assign in_col  = i_s_tdata[SIG_W+VALUE_W+MASK_W+COL_W-1:SIG_W+VALUE_W+MASK_W];
    assign in_cmd  = t_cmd'(i_s_tuser);

    logic accept;
    logic rank_ok;
    logic sig_ok;
    logic col_ok;
    logic start_upd;
    logic start_rd;
    logic do_clear;

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign rank_ok    = (in_rank != '0) && (32'(in_rank) <= MAX_ROWS);
    assign sig_ok     = (32'(in_sig) < NUM_SIGNATURES);
    assign col_ok     = (32'(in_col) < NUM_COLUMNS);

    always_comb begin
        start_upd = 1'b0;
        start_rd  = 1'b0;
        do_clear  = 1'b0;
        if (accept) begin
            case (in_cmd)
                CMD_UPDATE: start_upd = rank_ok && sig_ok;
                CMD_READ:   start_rd  = 1'b1;
                CMD_CLEAR:  do_clear  = 1'b1;
                default:    ; // unused code: drop the beat
            endcase
        end
    end

    // Lane control: read at accept, write back in the ST_LOOK state of an update
    t_lane_ctrl lane_ctrl;
    logic       slot_is_valid;

    assign slot_is_valid = r_slot_valid[r_slot[SLOT_W-1:0]];

    always_comb begin
        lane_ctrl.rd_en = start_upd || start_rd;
        lane_ctrl.wr_en = (r_state == ST_LOOK) && r_is_upd;
        lane_ctrl.fresh = !slot_is_valid;
        lane_ctrl.slot  = (r_state == ST_IDLE) ? in_sig : r_slot;
        lane_ctrl.rank  = r_rank;
        lane_ctrl.mask  = r_mask;
    end

    logic [VALUE_W-1:0] lane_data [NUM_COLUMNS];

    generate
        for (genvar k = 0; k < NUM_COLUMNS; k++) begin : g_lane
            mhsb_lane #(
                .NUM_SLOTS (NUM_SLOTS),
                .LANE      (k)
            ) u_lane (
                .i_clk     (i_clk),
                .i_ctrl    (lane_ctrl),
                .o_rd_data (lane_data[k])
            );
        end
    endgenerate

    // Merge the lanes for a read
    logic               force_empty;
    logic [VALUE_W-1:0] merge_value;
    logic               merge_empty;

    assign force_empty = r_bad ? 1'b1 : !slot_is_valid;

    mhsb_merge #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_merge (
        .i_lane_data   (lane_data),
        .i_col         (r_col),
        .i_force_empty (force_empty),
        .o_value       (merge_value),
        .o_empty       (merge_empty)
    );

    logic out_free;
    logic rd_done;
    assign out_free = !r_out_valid || i_m_tready;
    // A read finishes when its result can move into the output register
    assign rd_done  = (r_state == ST_LOOK) && !r_is_upd && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_out_valid  <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            // Load a finished read, else drop the held result once the sink takes it
            if (rd_done) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (do_clear) begin
                        r_slot_valid <= '0;
                    end
                    if (start_upd || start_rd) begin
                        r_state <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (r_is_upd) begin
                        r_slot_valid[r_slot[SLOT_W-1:0]] <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Payload registers: hold the accepted item and the result beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_upd <= (in_cmd == CMD_UPDATE);
            r_slot   <= in_sig;
            r_rank   <= in_rank;
            r_mask   <= in_mask;
            r_col    <= in_col;
            r_bad    <= !sig_ok || !col_ok;
        end
        if (rd_done) begin
            r_out_value <= merge_value;
            r_out_empty <= merge_empty;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {{(24 - VALUE_W){1'b0}}, r_out_value};
    assign o_m_tuser[0] = r_out_empty;

    `MHSB_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid && r_slot_valid == '0), "reset left control state set")
    `MHSB_ASSERT(a_clear_all, i_clk, i_rst_n, do_clear |=> (r_slot_valid == '0), "clear left a slot valid")
    `MHSB_ASSERT(a_update_marks, i_clk, i_rst_n, (r_state == ST_LOOK && r_is_upd) |=> r_slot_valid[$past(r_slot[SLOT_W-1:0])], "update did not mark its slot")
    `MHSB_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_m_tvalid) |-> $past(r_state == ST_LOOK && !r_is_upd), "result beat without a read")
    `MHSB_ASSERT(a_empty_flag, i_clk, i_rst_n, o_m_tvalid |-> (r_out_empty == (r_out_value == SENTINEL)), "empty flag disagrees with value")

endmodule

FILE: tb/minhash_signature_builder_test.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the MinHash signature builder.
module minhash_signature_builder_test;
    import mhsb_pkg::*;

    localparam int NUM_COLUMNS    = 16;
    localparam int NUM_SIGNATURES = 256;
    localparam int MAX_ROWS       = 65536;
    // tuser code with no meaning to the block: must change nothing
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // cycles with no beat on either side before the run is abandoned
    localparam int IDLE_LIMIT     = 2000;
    localparam int RANDOM_BEATS   = 1400;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [SIG_W-1:0]   slot;
        logic [VALUE_W-1:0] rank;
        logic [MASK_W-1:0]  mask;
        logic [COL_W-1:0]   col;
    } t_beat;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               empty;
    } t_entry;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // tdata: sig_index[7:0], row_rank[24:8], column_mask[40:25], read_column[44:41]
    logic [47:0] i_s_tdata  = '0;
    // tuser: cmd[1:0]
    logic [1:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // tdata: sig_value[16:0]
    logic [23:0] o_m_tdata;
    // tuser: sig_empty[0]
    logic [0:0]  o_m_tuser;

    // Beats waiting to be driven, and read results still owed by the block
    t_beat  beat_q[$];
    t_entry expected_reads[$];
    t_beat  in_flight;

    // Predicted signature state
    bit                 slot_valid [NUM_SIGNATURES];
    logic [VALUE_W-1:0] sig_store  [NUM_SIGNATURES][NUM_COLUMNS];

    int mismatches  = 0;
    int idle_cycles = 0;
    int tx_gap      = 0;
    bit tx_calm     = 1'b0;
    int rx_stall    = 0;
    bit rx_calm     = 1'b0;
    int beats_taken = 0;

    minhash_signature_builder #(
        .NUM_COLUMNS   (NUM_COLUMNS),
        .NUM_SIGNATURES(NUM_SIGNATURES),
        .MAX_ROWS      (MAX_ROWS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch in %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [SIG_W-1:0] slot,
                              input logic [VALUE_W-1:0] rank, input logic [MASK_W-1:0] mask,
                              input logic [COL_W-1:0] col);
        t_beat b;
        b.cmd  = cmd;
        b.slot = slot;
        b.rank = rank;
        b.mask = mask;
        b.col  = col;
        beat_q.push_back(b);
    endtask

    // Fold one accepted beat into the predicted signatures; a read owes one result
    task automatic fold_beat(input t_beat b);
        logic [VALUE_W-1:0] cur;
        t_entry             e;
        int                 k;
        case (b.cmd)
            CMD_UPDATE: begin
                // drop ranks of zero or past the last row, and slots past the table
                if (b.slot < NUM_SIGNATURES && b.rank != '0 && b.rank <= MAX_ROWS) begin
                    for (k = 0; k < NUM_COLUMNS; k++) begin
                        // a fresh slot starts every column empty
                        cur = slot_valid[b.slot] ? sig_store[b.slot][k] : SENTINEL;
                        if (k < MASK_W && b.mask[k] && b.rank < cur)
                            cur = b.rank;
                        sig_store[b.slot][k] = cur;
                    end
                    slot_valid[b.slot] = 1'b1;
                end
            end
            CMD_READ: begin
                if (b.slot < NUM_SIGNATURES && b.col < NUM_COLUMNS && slot_valid[b.slot])
                    e.value = sig_store[b.slot][b.col];
                else
                    e.value = SENTINEL;
                e.empty = (e.value == SENTINEL);
                expected_reads.push_back(e);
            end
            CMD_CLEAR: begin
                foreach (slot_valid[i])
                    slot_valid[i] = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Driver: hold each beat until taken, then wait out its drawn gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                fold_beat(in_flight);
                beats_taken <= beats_taken + 1;
            end
            if (tx_gap > 0) begin
                tx_gap     <= tx_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (beat_q.size() != 0) begin
                in_flight  = beat_q.pop_front();
                i_s_tdata  <= {3'b000, in_flight.col, in_flight.mask, in_flight.rank,
                               in_flight.slot};
                i_s_tuser  <= in_flight.cmd;
                i_s_tvalid <= 1'b1;
                // switch now and then between back-to-back bursts and random gaps
                if ($urandom_range(0, 39) == 0)
                    tx_calm <= !tx_calm;
                tx_gap <= tx_calm ? 0 : int'($urandom_range(0, 6));
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result beat with the oldest owed read, then stall at random
    always @(posedge i_clk) begin : monitor
        int     stall;
        t_entry want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (o_m_tvalid && i_m_tready) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("unexpected result beat", int'(o_m_tdata[VALUE_W-1:0]), -1);
            end else begin
                want = expected_reads.pop_front();
                if (o_m_tdata[VALUE_W-1:0] !== want.value)
                    report_mismatch("sig_value", int'(o_m_tdata[VALUE_W-1:0]),
                                    int'(want.value));
                if (o_m_tuser[0] !== want.empty)
                    report_mismatch("sig_empty", int'(o_m_tuser[0]), int'(want.empty));
            end
            if ($urandom_range(0, 29) == 0)
                rx_calm <= !rx_calm;
            stall      = rx_calm ? 0 : int'($urandom_range(0, 6));
            rx_stall   <= stall;
            i_m_tready <= (stall == 0);
        end else if (rx_stall > 0) begin
            rx_stall   <= rx_stall - 1;
            i_m_tready <= (rx_stall == 1);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog: abandon the run after a long stretch with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [SIG_W-1:0]   pool [6];
        logic [SIG_W-1:0]   slot;
        logic [VALUE_W-1:0] rank;
        logic [MASK_W-1:0]  mask;
        int                 pool_n;
        int                 useful;
        int                 k;
        int                 beats_total;

        // Directed: empty read, first update, min keeping, edges, dropped ranks,
        // empty mask, unused command, clear followed by a fresh row
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_UPDATE, 8'd0,   17'd100,    16'h0001, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd1);
        queue_beat(CMD_UPDATE, 8'd0,   17'd50,     16'hFFFF, 4'd0);
        queue_beat(CMD_UPDATE, 8'd0,   17'd200,    16'hFFFF, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd15);
        queue_beat(CMD_UPDATE, 8'd255, 17'd1,      16'h8000, 4'd0);
        queue_beat(CMD_READ,   8'd255, 17'd0,      16'h0000, 4'd15);
        queue_beat(CMD_UPDATE, 8'd254, 17'd65536,  16'hFFFF, 4'd0);
        queue_beat(CMD_READ,   8'd254, 17'd0,      16'h0000, 4'd3);
        queue_beat(CMD_UPDATE, 8'd1,   17'd0,      16'hFFFF, 4'd0);
        queue_beat(CMD_UPDATE, 8'd1,   17'd65537,  16'hFFFF, 4'd0);
        queue_beat(CMD_UPDATE, 8'd1,   17'h1FFFF,  16'hFFFF, 4'd0);
        queue_beat(CMD_READ,   8'd1,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_UPDATE, 8'd3,   17'd7,      16'h0000, 4'd0);
        queue_beat(CMD_READ,   8'd3,   17'd0,      16'h0000, 4'd5);
        queue_beat(CMD_UPDATE, 8'd3,   17'd9,      16'h0020, 4'd0);
        queue_beat(CMD_READ,   8'd3,   17'd0,      16'h0000, 4'd5);
        queue_beat(CMD_UNUSED, 8'hFF,  17'h1FFFF,  16'hFFFF, 4'hF);
        queue_beat(CMD_CLEAR,  8'd0,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_UPDATE, 8'd0,   17'd300,    16'h0002, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd0,      16'h0000, 4'd0);
        queue_beat(CMD_READ,   8'd0,   17'd1,      16'h0000, 4'd1);

        // Random: passes over a few slots, rows streamed in, then columns read back
        useful = 0;
        while (useful < RANDOM_BEATS) begin
            pool_n = $urandom_range(1, 6);
            for (k = 0; k < pool_n; k++)
                pool[k] = SIG_W'($urandom);
            repeat ($urandom_range(8, 40)) begin
                slot = pool[$urandom_range(0, pool_n - 1)];
                case ($urandom_range(0, 3))
                    0:       rank = VALUE_W'($urandom_range(1, 64));
                    1:       rank = ($urandom_range(0, 1) != 0) ? VALUE_W'(1) : VALUE_W'(MAX_ROWS);
                    default: rank = VALUE_W'($urandom_range(1, MAX_ROWS));
                endcase
                case ($urandom_range(0, 3))
                    0:       mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
                    1:       mask = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    default: mask = MASK_W'($urandom);
                endcase
                case ($urandom_range(0, 19))
                    0: begin
                        // noise: unused command with random fields
                        queue_beat(CMD_UNUSED, SIG_W'($urandom), VALUE_W'($urandom),
                                   MASK_W'($urandom), COL_W'($urandom));
                    end
                    1: begin
                        // broken row: rank of zero or past the last row
                        rank = ($urandom_range(0, 1) != 0) ? '0 :
                               VALUE_W'($urandom_range(MAX_ROWS + 1, 131071));
                        queue_beat(CMD_UPDATE, slot, rank, mask, COL_W'($urandom));
                    end
                    2, 3: begin
                        queue_beat(CMD_READ, slot, VALUE_W'($urandom), MASK_W'($urandom),
                                   COL_W'($urandom));
                        useful++;
                    end
                    default: begin
                        queue_beat(CMD_UPDATE, slot, rank, mask, COL_W'($urandom));
                        useful++;
                    end
                endcase
            end
            repeat ($urandom_range(4, 20)) begin
                slot = ($urandom_range(0, 7) == 0) ? SIG_W'($urandom)
                                                    : pool[$urandom_range(0, pool_n - 1)];
                queue_beat(CMD_READ, slot, VALUE_W'($urandom), MASK_W'($urandom),
                           COL_W'($urandom));
                useful++;
            end
            if ($urandom_range(0, 3) == 0) begin
                queue_beat(CMD_CLEAR, SIG_W'($urandom), VALUE_W'($urandom), MASK_W'($urandom),
                           COL_W'($urandom));
                useful++;
            end
        end
        beats_total = beat_q.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every beat taken, every owed read back, then a short settle
        while (beats_taken < beats_total)
            @(posedge i_clk);
        while (expected_reads.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/mhsb_pkg.sv
sv/mhsb_lane.sv
sv/mhsb_merge.sv
sv/minhash_signature_builder.sv
tb/minhash_signature_builder_test.sv
